### rtl/core/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg: shared types and helpers of the three-component vector unit
// Holds the beat payloads, the operation codes, the internal sideband that
// travels with each item, and the sign extension and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package v3a_pkg;

  // Fixed widths of the port fields and of the square root datapath.
  localparam int unsigned DataBits = 32;
  localparam int unsigned SqBits   = 64;
  localparam int unsigned LenBits  = 32;
  localparam int unsigned WideBits = 68;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DOT   = 3'd3,
    OP_CROSS = 3'd4,
    OP_LENSQ = 3'd5,
    OP_LEN   = 3'd6,
    OP_NORM  = 3'd7
  } v3a_op_e;

  typedef struct packed {
    v3a_op_e            op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] factor;
  } v3a_in_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] rs;
    logic               overflow;
    logic               zero_length;
  } v3a_out_t;

  // Sideband carried down the pipeline: operation, vector A and the results
  // that are already final for the operations that need no square root.
  typedef struct packed {
    v3a_op_e           op;
    logic [2:0][31:0]  av;
    logic [2:0][31:0]  rv;
    logic [31:0]       rs;
    logic              ovf;
  } v3a_side_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] word;
  } v3a_sat_t;

  // Keep the low eff bits of a component and sign-extend them.
  function automatic logic signed [31:0] sext_word(input logic [31:0] raw,
                                                   input int unsigned eff);
    logic signed [31:0] t;
    t = $signed(raw << (DataBits - eff));
    return t >>> (DataBits - eff);
  endfunction

  // Clamp a wide signed value to eff signed bits and flag the clamp.
  function automatic v3a_sat_t sat_word(input logic signed [WideBits-1:0] v,
                                        input int unsigned eff);
    logic signed [WideBits-1:0] hi;
    logic signed [WideBits-1:0] lo;
    v3a_sat_t                   r;
    hi = (WideBits'(1) <<< (eff - 1)) - WideBits'(1);
    lo = -hi - WideBits'(1);
    r.ovf  = 1'b0;
    r.word = v[31:0];
    if (v > hi) begin
      r.ovf  = 1'b1;
      r.word = hi[31:0];
    end else if (v < lo) begin
      r.ovf  = 1'b1;
      r.word = lo[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/v3a_front.sv
// ----------------------------------------------------------------------------
// v3a_front: operand, multiply and combine stages
// Three register stages: input capture with sign extension, six parallel
// 32x32 products, then the sums, shifts and saturation of the direct ops.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_front
  import v3a_pkg::*;
#(
  parameter int unsigned EffBits  = 32,
  parameter int unsigned FracBits = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire v3a_in_t           data_i,
  output logic                   vld_o,
  output v3a_side_t              side_o,
  output logic [SqBits-1:0]      sq_o
);

  // Stage A: captured and sign-extended operands.
  logic               vld_a_q;
  v3a_op_e            op_a_q;
  logic signed [31:0] a_a_q [3];
  logic signed [31:0] b_a_q [3];
  logic signed [31:0] f_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_a_q   <= data_i.op;
      a_a_q[0] <= sext_word(data_i.ax, EffBits);
      a_a_q[1] <= sext_word(data_i.ay, EffBits);
      a_a_q[2] <= sext_word(data_i.az, EffBits);
      b_a_q[0] <= sext_word(data_i.bx, EffBits);
      b_a_q[1] <= sext_word(data_i.by, EffBits);
      b_a_q[2] <= sext_word(data_i.bz, EffBits);
      f_a_q    <= sext_word(data_i.factor, EffBits);
    end
  end

  // Operand selection for the six multipliers.
  logic signed [31:0] ma [6];
  logic signed [31:0] mb [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = a_a_q[i % 3];
      mb[i] = a_a_q[i % 3];
    end
    case (op_a_q)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) mb[i] = f_a_q;
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) mb[i] = b_a_q[i];
      end
      OP_CROSS: begin
        ma[0] = a_a_q[1]; mb[0] = b_a_q[2];
        ma[1] = a_a_q[2]; mb[1] = b_a_q[1];
        ma[2] = a_a_q[2]; mb[2] = b_a_q[0];
        ma[3] = a_a_q[0]; mb[3] = b_a_q[2];
        ma[4] = a_a_q[0]; mb[4] = b_a_q[1];
        ma[5] = a_a_q[1]; mb[5] = b_a_q[0];
      end
      default: begin
      end
    endcase
  end

  // Stage B: products and the add or subtract of each component.
  logic               vld_b_q;
  v3a_op_e            op_b_q;
  logic signed [31:0] a_b_q [3];
  logic signed [63:0] p_b_q [6];
  logic signed [32:0] s_b_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_b_q <= op_a_q;
      for (int i = 0; i < 6; i++) p_b_q[i] <= ma[i] * mb[i];
      for (int i = 0; i < 3; i++) begin
        a_b_q[i] <= a_a_q[i];
        s_b_q[i] <= (op_a_q == OP_SUB) ? (33'(a_a_q[i]) - 33'(b_a_q[i]))
                                       : (33'(a_a_q[i]) + 33'(b_a_q[i]));
      end
    end
  end

  // Sums, fraction shift and saturation of the direct operations.
  logic signed [WideBits-1:0] sum3;
  logic signed [WideBits-1:0] cr [3];
  v3a_sat_t                   st [3];
  v3a_sat_t                   ss;
  v3a_side_t                  side_d;

  always_comb begin
    sum3  = WideBits'(p_b_q[0]) + WideBits'(p_b_q[1]) + WideBits'(p_b_q[2]);
    cr[0] = WideBits'(p_b_q[0]) - WideBits'(p_b_q[1]);
    cr[1] = WideBits'(p_b_q[2]) - WideBits'(p_b_q[3]);
    cr[2] = WideBits'(p_b_q[4]) - WideBits'(p_b_q[5]);
    ss    = sat_word(sum3 >>> FracBits, EffBits);
    for (int i = 0; i < 3; i++) begin
      case (op_b_q)
        OP_ADD, OP_SUB: st[i] = sat_word(WideBits'(s_b_q[i]), EffBits);
        OP_SCALE:       st[i] = sat_word(WideBits'(p_b_q[i]) >>> FracBits, EffBits);
        default:        st[i] = sat_word(cr[i] >>> FracBits, EffBits);
      endcase
    end

    side_d.op  = op_b_q;
    side_d.rs  = '0;
    side_d.ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      side_d.av[i] = a_b_q[i];
      side_d.rv[i] = '0;
    end
    case (op_b_q)
      OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
        for (int i = 0; i < 3; i++) side_d.rv[i] = st[i].word;
        side_d.ovf = st[0].ovf | st[1].ovf | st[2].ovf;
      end
      OP_DOT, OP_LENSQ: begin
        side_d.rs  = ss.word;
        side_d.ovf = ss.ovf;
      end
      default: begin
      end
    endcase
  end

  // Stage C: sideband and the sum of squares for the square root.
  logic      vld_c_q;
  v3a_side_t side_c_q;
  logic [SqBits-1:0] sq_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else if (en_i) begin
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_c_q <= side_d;
      sq_c_q   <= sum3[SqBits-1:0];
    end
  end

  assign vld_o  = vld_c_q;
  assign side_o = side_c_q;
  assign sq_o   = sq_c_q;

endmodule

`default_nettype wire

### rtl/core/v3a_sqrt.sv
// ----------------------------------------------------------------------------
// v3a_sqrt: pipelined integer square root
// One result bit per stage, restoring method, 32 stages for a 64-bit operand.
// The item sideband travels alongside unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_sqrt
  import v3a_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire v3a_side_t          side_i,
  input  wire logic [SqBits-1:0]  sq_i,
  output logic                    vld_o,
  output v3a_side_t               side_o,
  output logic [LenBits-1:0]      len_o
);

  localparam int unsigned Steps   = LenBits;
  localparam int unsigned RemBits = LenBits + 3;

  logic                vld_q  [Steps];
  v3a_side_t           side_q [Steps];
  logic [LenBits-1:0]  res_q  [Steps];
  logic [SqBits-1:0]   n_q    [Steps-1];
  logic [RemBits-1:0]  rem_q  [Steps-1];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic               v_in;
    v3a_side_t          s_in;
    logic [SqBits-1:0]  n_in;
    logic [RemBits-1:0] rem_in;
    logic [LenBits-1:0] res_in;
    logic [RemBits-1:0] rem_sh;
    logic [RemBits-1:0] trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign v_in   = vld_i;
      assign s_in   = side_i;
      assign n_in   = sq_i;
      assign rem_in = '0;
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = vld_q[k-1];
      assign s_in   = side_q[k-1];
      assign n_in   = n_q[k-1];
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    // Bring down the next two operand bits and try the next result bit.
    assign rem_sh = {rem_in[RemBits-3:0], n_in[SqBits-1:SqBits-2]};
    assign trial  = {1'b0, res_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= s_in;
        res_q[k]  <= {res_in[LenBits-2:0], ge};
      end
    end

    if (k < Steps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          n_q[k]   <= {n_in[SqBits-3:0], 2'b00};
          rem_q[k] <= ge ? (rem_sh - trial) : rem_sh;
        end
      end
    end
  end

  assign vld_o  = vld_q[Steps-1];
  assign side_o = side_q[Steps-1];
  assign len_o  = res_q[Steps-1];

endmodule

`default_nettype wire

### rtl/core/v3a_div.sv
// ----------------------------------------------------------------------------
// v3a_div: pipelined divider for the normalize operation
// Three lanes divide |a| scaled by the fraction by the length, one quotient
// bit per stage. Since |a| never exceeds the length, FracBits+1 bits suffice.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_div
  import v3a_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     vld_i,
  input  wire v3a_side_t                side_i,
  input  wire logic [LenBits-1:0]       len_i,
  output logic                          vld_o,
  output v3a_side_t                     side_o,
  output logic [LenBits-1:0]            len_o,
  output logic [2:0][FracBits:0]        quo_o
);

  localparam int unsigned Steps = FracBits + 1;

  logic                          vld_q  [Steps];
  v3a_side_t                     side_q [Steps];
  logic [LenBits-1:0]            len_q  [Steps];
  logic [2:0][FracBits:0]        quo_q  [Steps];
  logic [2:0][LenBits:0]         rem_q  [Steps-1];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic                   v_in;
    v3a_side_t              s_in;
    logic [LenBits-1:0]     d_in;
    logic [2:0][FracBits:0] q_in;
    logic [2:0][LenBits:0]  r_in;
    logic [2:0][LenBits:0]  r_d;
    logic [2:0]             ge;

    if (k == 0) begin : g_first
      // The first partial remainder is the magnitude of the component.
      for (genvar j = 0; j < 3; j++) begin : g_mag
        assign r_in[j] = {1'b0, side_i.av[j][31] ? (~side_i.av[j] + 32'd1)
                                                 : side_i.av[j]};
      end
      assign v_in = vld_i;
      assign s_in = side_i;
      assign d_in = len_i;
      assign q_in = '0;
    end else begin : g_next
      for (genvar j = 0; j < 3; j++) begin : g_sh
        assign r_in[j] = {rem_q[k-1][j][LenBits-1:0], 1'b0};
      end
      assign v_in = vld_q[k-1];
      assign s_in = side_q[k-1];
      assign d_in = len_q[k-1];
      assign q_in = quo_q[k-1];
    end

    // Compare and subtract in each lane.
    for (genvar j = 0; j < 3; j++) begin : g_lane
      assign ge[j]  = (r_in[j] >= {1'b0, d_in});
      assign r_d[j] = ge[j] ? (r_in[j] - {1'b0, d_in}) : r_in[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= s_in;
        len_q[k]  <= d_in;
        for (int j = 0; j < 3; j++) quo_q[k][j] <= {q_in[j][FracBits-1:0], ge[j]};
      end
    end

    if (k < Steps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= r_d;
        end
      end
    end
  end

  assign vld_o  = vld_q[Steps-1];
  assign side_o = side_q[Steps-1];
  assign len_o  = len_q[Steps-1];
  assign quo_o  = quo_q[Steps-1];

endmodule

`default_nettype wire

### rtl/core/vector3_arith_unit.sv
// ----------------------------------------------------------------------------
// vector3_arith_unit: three-component fixed-point vector unit
// Add, subtract, scale, dot, cross, squared length, length and normalize on
// signed Q-format vectors, with saturation and flags.
// ----------------------------------------------------------------------------
// The unit takes one beat per cycle while no finished beat is held at the output
// and returns one result beat per input beat, in order. The path runs through
// three front stages for operand capture, the products and the sums, 32 square
// root stages at one result bit each, FRAC_BITS + 1 divider stages at one
// quotient bit each, and the output register. Every operation flows through the
// same stages. When the output beat is not taken, the whole pipeline holds, so
// in_ready_o drops in that cycle.
`default_nettype none

module vector3_arith_unit
  import v3a_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire v3a_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output v3a_out_t      out_data_o
);

  localparam int unsigned EffBits = (WORD_BITS < DataBits) ? WORD_BITS : DataBits;

  logic en;

  logic              fr_vld;
  v3a_side_t         fr_side;
  logic [SqBits-1:0] fr_sq;

  logic               sq_vld;
  v3a_side_t          sq_side;
  logic [LenBits-1:0] sq_len;

  logic                    dv_vld;
  v3a_side_t               dv_side;
  logic [LenBits-1:0]      dv_len;
  logic [2:0][FRAC_BITS:0] dv_quo;

  logic     out_vld_q;
  v3a_out_t out_q;
  v3a_op_e  out_op_q;

  // The pipeline advances unless a finished beat waits at the output.
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  v3a_front #(
    .EffBits (EffBits),
    .FracBits(FRAC_BITS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (in_valid_i),
    .data_i(in_data_i),
    .vld_o (fr_vld),
    .side_o(fr_side),
    .sq_o  (fr_sq)
  );

  v3a_sqrt u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (fr_vld),
    .side_i(fr_side),
    .sq_i  (fr_sq),
    .vld_o (sq_vld),
    .side_o(sq_side),
    .len_o (sq_len)
  );

  v3a_div #(
    .FracBits(FRAC_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (sq_vld),
    .side_i(sq_side),
    .len_i (sq_len),
    .vld_o (dv_vld),
    .side_o(dv_side),
    .len_o (dv_len),
    .quo_o (dv_quo)
  );

  // Final assembly: length and normalize results, signs and saturation.
  v3a_sat_t                   len_sat;
  v3a_sat_t                   nrm_sat [3];
  logic signed [WideBits-1:0] qs;
  v3a_out_t                   out_d;

  always_comb begin
    len_sat = sat_word(WideBits'(dv_len), EffBits);
    for (int i = 0; i < 3; i++) begin
      qs         = WideBits'(dv_quo[i]);
      nrm_sat[i] = sat_word(dv_side.av[i][31] ? -qs : qs, EffBits);
    end

    out_d.rx          = dv_side.rv[0];
    out_d.ry          = dv_side.rv[1];
    out_d.rz          = dv_side.rv[2];
    out_d.rs          = dv_side.rs;
    out_d.overflow    = dv_side.ovf;
    out_d.zero_length = 1'b0;
    case (dv_side.op)
      OP_LEN: begin
        out_d.rs       = len_sat.word;
        out_d.overflow = len_sat.ovf;
      end
      OP_NORM: begin
        if (dv_len == '0) begin
          out_d.zero_length = 1'b1;
          out_d.overflow    = 1'b0;
          out_d.rx          = '0;
          out_d.ry          = '0;
          out_d.rz          = '0;
          out_d.rs          = '0;
        end else begin
          out_d.rx       = nrm_sat[0].word;
          out_d.ry       = nrm_sat[1].word;
          out_d.rz       = nrm_sat[2].word;
          out_d.rs       = len_sat.word;
          out_d.overflow = nrm_sat[0].ovf | nrm_sat[1].ovf | nrm_sat[2].ovf
                         | len_sat.ovf;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q    <= out_d;
      out_op_q <= dv_side.op;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A held output beat must stop the intake.
  a_stall_blocks_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while the output beat is held");

  // A zero-length result carries only zeros and no overflow.
  a_zero_length_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_length) |->
      (out_data_o.rx == '0 && out_data_o.ry == '0 && out_data_o.rz == '0 &&
       out_data_o.rs == '0 && !out_data_o.overflow))
    else $error("zero-length beat with nonzero payload");

  // Only the normalize operation may report a zero length.
  a_zero_length_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_length) |-> (out_op_q == OP_NORM))
    else $error("zero-length flag on an operation other than normalize");

  // Scalar operations leave the result vector at zero.
  a_scalar_ops_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_op_q == OP_DOT || out_op_q == OP_LENSQ ||
                     out_op_q == OP_LEN)) |->
      (out_data_o.rx == '0 && out_data_o.ry == '0 && out_data_o.rz == '0))
    else $error("scalar operation produced a nonzero vector");

endmodule

`default_nettype wire

### test/v3a_checker.sv
// ----------------------------------------------------------------------------
// v3a_checker: result predictor and scoreboard for the vector unit
// Watches both channels. Each accepted input beat is turned into the result
// that the unit must return, and each accepted output beat is compared, field
// by field, with the oldest result still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_checker
  import v3a_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_ready_i,
  input  wire v3a_in_t  in_data_i,
  input  wire logic     out_valid_i,
  input  wire logic     out_ready_i,
  input  wire v3a_out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);

  localparam int unsigned FracBits = 16;

  v3a_out_t result_q[$];

  // Clamp a wide value to a signed 32-bit word and note the clamp.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Truncated integer square root, one result bit per pass.
  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] probe;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Work out the result beat that one input beat must produce.
  function automatic v3a_out_t vector_result(input v3a_in_t t);
    logic signed [127:0] a[3];
    logic signed [127:0] b[3];
    logic signed [127:0] f;
    logic signed [127:0] acc;
    logic signed [127:0] len_w;
    logic [63:0]         sq;
    logic [63:0]         len;
    logic [63:0]         m;
    logic                ovf;
    logic [31:0]         r[3];
    logic [31:0]         s;
    v3a_out_t            res;
    a[0] = $signed(t.ax); a[1] = $signed(t.ay); a[2] = $signed(t.az);
    b[0] = $signed(t.bx); b[1] = $signed(t.by); b[2] = $signed(t.bz);
    f    = $signed(t.factor);
    ovf  = 1'b0;
    r[0] = '0; r[1] = '0; r[2] = '0;
    s    = '0;
    res.zero_length = 1'b0;
    case (t.op)
      OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], ovf);
      OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] - b[i], ovf);
      OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp32((a[i] * f) >>> FracBits, ovf);
      OP_DOT: begin
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        s = clamp32(acc >>> FracBits, ovf);
      end
      OP_CROSS: begin
        r[0] = clamp32((a[1] * b[2] - a[2] * b[1]) >>> FracBits, ovf);
        r[1] = clamp32((a[2] * b[0] - a[0] * b[2]) >>> FracBits, ovf);
        r[2] = clamp32((a[0] * b[1] - a[1] * b[0]) >>> FracBits, ovf);
      end
      OP_LENSQ: begin
        acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        s = clamp32(acc >>> FracBits, ovf);
      end
      default: begin
        // Length and normalize share the square root of the sum of squares.
        sq = '0;
        for (int i = 0; i < 3; i++) begin
          m  = a[i] < 0 ? 64'(-a[i]) : 64'(a[i]);
          sq = sq + m * m;
        end
        len   = int_sqrt(sq);
        len_w = $signed({64'd0, len});
        if (t.op == OP_LEN) begin
          s = clamp32(len_w, ovf);
        end else if (len == 0) begin
          res.zero_length = 1'b1;
        end else begin
          // Division truncates toward zero, as the unit's divider does.
          for (int i = 0; i < 3; i++) r[i] = clamp32((a[i] <<< FracBits) / len_w, ovf);
          s = clamp32(len_w, ovf);
        end
      end
    endcase
    res.rx = r[0];
    res.ry = r[1];
    res.rz = r[2];
    res.rs = s;
    res.overflow = ovf;
    return res;
  endfunction

  // Compare outgoing beats first, then queue the prediction for a new input.
  always @(posedge clk_i or negedge rst_ni) begin
    v3a_out_t want;
    if (!rst_ni) begin
      result_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("tb: result beat with none expected: %p", out_data_i);
        end else begin
          want = result_q.pop_front();
          if (out_data_i.rx !== want.rx || out_data_i.ry !== want.ry ||
              out_data_i.rz !== want.rz || out_data_i.rs !== want.rs ||
              out_data_i.overflow !== want.overflow ||
              out_data_i.zero_length !== want.zero_length) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("tb: mismatch expected rx=%h ry=%h rz=%h rs=%h ovf=%b zl=%b",
                       want.rx, want.ry, want.rz, want.rs, want.overflow, want.zero_length);
              $display("tb:            actual rx=%h ry=%h rz=%h rs=%h ovf=%b zl=%b",
                       out_data_i.rx, out_data_i.ry, out_data_i.rz, out_data_i.rs,
                       out_data_i.overflow, out_data_i.zero_length);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) result_q.push_back(vector_result(in_data_i));
      pending_o = result_q.size();
    end
  end

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the vector unit
// Sends directed corner beats for every operation, then random beats with
// random gaps and output stalls, one long output hold-off that fills the
// pipeline, and one pause that lets the pipeline drain. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import v3a_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 80;
  localparam logic [31:0] WordMax = 32'h7fff_ffff;
  localparam logic [31:0] WordMin = 32'h8000_0000;
  localparam logic [31:0] One = 32'h0001_0000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  v3a_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  v3a_out_t out_data;
  int       fail_count;
  int       pending;
  int       cycles;
  logic     hold_req;
  logic     no_idle;

  vector3_arith_unit u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  v3a_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and run limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  function automatic v3a_in_t make_beat(v3a_op_e op, logic [31:0] ax, logic [31:0] ay,
                                        logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                                        logic [31:0] bz, logic [31:0] factor);
    v3a_in_t t;
    t.op = op;
    t.ax = ax; t.ay = ay; t.az = az;
    t.bx = bx; t.by = by; t.bz = bz;
    t.factor = factor;
    return t;
  endfunction

  // One random component: full range, small, medium, non-negative below One, or a corner value.
  function automatic logic [31:0] rand_comp();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h001f_ffff) - 32'h0010_0000;
      2: v = $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000;
      3: v = $urandom_range(0, 32'h0000_ffff);
      default: begin
        case ($urandom_range(0, 5))
          0: v = WordMax;
          1: v = WordMin;
          2: v = '0;
          3: v = One;
          4: v = -One;
          default: v = 32'hffff_ffff;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic v3a_in_t rand_beat();
    v3a_in_t t;
    t = make_beat(v3a_op_e'($urandom_range(0, 7)), rand_comp(), rand_comp(), rand_comp(),
                  rand_comp(), rand_comp(), rand_comp(), rand_comp());
    // Now and then a zero vector A, so normalize sees its special case.
    if ($urandom_range(0, 15) == 0) begin
      t.ax = '0; t.ay = '0; t.az = '0;
    end
    return t;
  endfunction

  // Offer one beat after a random gap and hold it until it is accepted.
  task automatic send_beat(input v3a_in_t t);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
  endtask

  // Result side: random stalls per beat, plus one long hold-off on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      forever begin
        @(negedge clk);
        if (out_valid || hold_req) break;
      end
      @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    v3a_in_t t;
    in_valid = 1'b0;
    in_data  = '0;
    hold_req = 1'b0;
    no_idle  = 1'b0;
    rst_n    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners of every operation.
    send_beat(make_beat(OP_ADD, WordMax, WordMin, One, One, -1, -One, '0));
    send_beat(make_beat(OP_ADD, WordMin, WordMax, '0, -1, 1, '0, '0));
    send_beat(make_beat(OP_SUB, WordMin, WordMax, '0, 1, -1, WordMax, '0));
    send_beat(make_beat(OP_SUB, WordMax, WordMin, -1, WordMin, WordMax, -1, '0));
    send_beat(make_beat(OP_SCALE, WordMax, WordMin, -One, '0, '0, '0, WordMax));
    send_beat(make_beat(OP_SCALE, -1, One, 32'h0000_8000, '0, '0, '0, WordMin));
    send_beat(make_beat(OP_SCALE, 32'h0003_0000, -32'h0003_0000, 1, '0, '0, '0, -1));
    send_beat(make_beat(OP_DOT, WordMin, WordMin, WordMin, WordMin, WordMin, WordMin, '0));
    send_beat(make_beat(OP_DOT, WordMax, WordMin, One, WordMin, WordMax, -1, '0));
    send_beat(make_beat(OP_DOT, -1, 1, -1, 1, 1, 1, '0));
    send_beat(make_beat(OP_CROSS, WordMax, WordMin, WordMax, WordMin, WordMax, WordMin, '0));
    send_beat(make_beat(OP_CROSS, One, '0, '0, '0, One, '0, '0));
    send_beat(make_beat(OP_LENSQ, WordMin, WordMin, WordMin, '0, '0, '0, '0));
    send_beat(make_beat(OP_LENSQ, -1, 1, 32'h0000_ffff, '0, '0, '0, '0));
    send_beat(make_beat(OP_LEN, WordMin, WordMin, WordMin, '0, '0, '0, '0));
    send_beat(make_beat(OP_LEN, '0, '0, '0, '0, '0, '0, '0));
    send_beat(make_beat(OP_LEN, 32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0, '0));
    send_beat(make_beat(OP_NORM, '0, '0, '0, WordMax, WordMin, 1, WordMax));
    send_beat(make_beat(OP_NORM, 1, '0, '0, '0, '0, '0, '0));
    send_beat(make_beat(OP_NORM, -1, -1, -1, '0, '0, '0, '0));
    send_beat(make_beat(OP_NORM, WordMin, WordMin, WordMin, '0, '0, '0, '0));
    send_beat(make_beat(OP_NORM, WordMax, '0, -One, '0, '0, '0, '0));
    send_beat(make_beat(OP_NORM, 32'h0003_0000, -32'h0004_0000, '0, '0, '0, '0, '0));

    // Random beats, with stretches of back-to-back traffic.
    for (int i = 0; i < 800; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (i == 200) hold_req = 1'b1;
      if (i == 450) begin
        in_valid <= 1'b0;
        forever begin
          @(negedge clk);
          if (pending == 0) break;
        end
        @(posedge clk);
      end
      t = rand_beat();
      send_beat(t);
    end
    in_valid <= 1'b0;

    // Drain and verdict.
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/core/v3a_pkg.sv
rtl/core/v3a_front.sv
rtl/core/v3a_sqrt.sv
rtl/core/v3a_div.sv
rtl/core/vector3_arith_unit.sv
test/v3a_checker.sv
test/tb.sv
